[hdl/pcm_pkg.sv]
package pcm_pkg;

  localparam int NumRegs   = 8;
  localparam int CfgIdxW   = 4;
  localparam int CoefW     = 32;

  // register map
  localparam logic [2:0] REG_X_COL    = 3'd0;
  localparam logic [2:0] REG_X_ROW    = 3'd1;
  localparam logic [2:0] REG_X_OFFSET = 3'd2;
  localparam logic [2:0] REG_Y_COL    = 3'd3;
  localparam logic [2:0] REG_Y_ROW    = 3'd4;
  localparam logic [2:0] REG_Y_OFFSET = 3'd5;
  localparam logic [2:0] REG_W_COL    = 3'd6;
  localparam logic [2:0] REG_W_ROW    = 3'd7;

  localparam logic signed [CoefW-1:0] CoefOne = 32'sd1048576;

  localparam int SumW  = 43;              // exact Q.20 / Q.28 sums
  localparam int NumW  = SumW + 8;        // numerator scaled by 2^8
  localparam int QuoW  = 15;              // quotient magnitude below 2^15
  localparam logic signed [SumW-1:0] WOne = 43'sd268435456;

  localparam logic [7:0] WhiteThreshold = 8'd5;
  localparam logic signed [15:0] SatPos = 16'sd32767;
  localparam logic signed [15:0] SatNeg = -16'sd32767;

  typedef struct packed {
    logic [8:0] pixel_col;
    logic [7:0] pixel_row;
    logic [7:0] pixel_value;
  } pixel_t;

  typedef struct packed {
    logic signed [15:0] mapped_x;
    logic signed [15:0] mapped_y;
    logic               is_white;
    logic               overflow;
  } result_t;

  // side info that travels with one quotient through the divider
  typedef struct packed {
    logic neg;      // quotient sign
    logic sat;      // magnitude would reach 2^15
    logic wzero;    // denominator is zero
    logic nneg;     // numerator negative
    logic nzero;    // numerator zero
  } quot_flags_t;

endpackage

[hdl/perspective_coordinate_mapper_top.sv]
// Channel   | Ports                                     | Direction | Handshake
// pixel     | start_i, busy_o, pixel_i                  | in        | start && !busy
// result    | result_valid_o, result_o                  | out       | strobe, one cycle
// config    | cfg_valid_i, cfg_ready_o, cfg_index_i/data | in        | valid && ready
//
// One pixel per clock; busy_o never rises. From accept to result strobe a pixel passes
// the product and sum stages, the magnitude and range-check stages, the
// one-bit-per-stage divider and a final sign and saturation stage.
// Reset clears the valid pipeline and reloads the identity matrix.
// The receiver cannot stall, so the pipeline simply advances every cycle.
module perspective_coordinate_mapper_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  pcm_pkg::pixel_t                pixel_i,
  output logic                           result_valid_o,
  output pcm_pkg::result_t               result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pcm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pcm_pkg::CoefW-1:0]      cfg_data_i
);

  localparam int SW  = pcm_pkg::SumW;
  localparam int Lat = 4 + pcm_pkg::QuoW;  // stages up to divider output

  // ---- coefficient registers; the user must write them only while idle (not enforced here)
  logic signed [pcm_pkg::CoefW-1:0] coef_q [pcm_pkg::NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pcm_pkg::NumRegs; i++) begin
        coef_q[i] <= (i == pcm_pkg::REG_X_COL || i == pcm_pkg::REG_Y_ROW) ?
                     pcm_pkg::CoefOne : '0;
      end
    end else if (cfg_valid_i && !cfg_index_i[pcm_pkg::CfgIdxW-1]) begin
      coef_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // ---- valid and threshold bit ride alongside the data
  logic [Lat:0]   vld_q;
  logic [Lat-1:0] wht_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-1:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    wht_q <= {wht_q[Lat-2:0], (pixel_i.pixel_value >= pcm_pkg::WhiteThreshold)};
  end

  // ---- stage 1: six narrow products (32 x 10 / 32 x 9 signed)
  logic signed [9:0]  col_s;
  logic signed [8:0]  row_s;
  logic signed [41:0] pxc_q, pxr_q, pyc_q, pyr_q, pwc_q, pwr_q;
  logic signed [pcm_pkg::CoefW-1:0] offx_q, offy_q;

  assign col_s = $signed({1'b0, pixel_i.pixel_col});
  assign row_s = $signed({1'b0, pixel_i.pixel_row});

  always_ff @(posedge clk_i) begin
    pxc_q  <= coef_q[pcm_pkg::REG_X_COL] * col_s;
    pxr_q  <= coef_q[pcm_pkg::REG_X_ROW] * row_s;
    pyc_q  <= coef_q[pcm_pkg::REG_Y_COL] * col_s;
    pyr_q  <= coef_q[pcm_pkg::REG_Y_ROW] * row_s;
    pwc_q  <= coef_q[pcm_pkg::REG_W_COL] * col_s;
    pwr_q  <= coef_q[pcm_pkg::REG_W_ROW] * row_s;
    offx_q <= coef_q[pcm_pkg::REG_X_OFFSET];
    offy_q <= coef_q[pcm_pkg::REG_Y_OFFSET];
  end

  // ---- stage 2: exact numerator and denominator sums
  logic signed [SW-1:0] nx_q, ny_q, w_q;

  always_ff @(posedge clk_i) begin
    nx_q <= SW'(pxc_q) + SW'(pxr_q) + SW'(offx_q);
    ny_q <= SW'(pyc_q) + SW'(pyr_q) + SW'(offy_q);
    w_q  <= SW'(pwc_q) + SW'(pwr_q) + pcm_pkg::WOne;
  end

  // ---- divider pipelines: (num * 2^8) / w
  logic [pcm_pkg::QuoW-1:0] qx, qy;
  pcm_pkg::quot_flags_t     fx, fy;

  pcm_divider u_div_x (
    .clk_i   (clk_i),
    .num_i   ({nx_q, 8'b0}),
    .den_i   (w_q),
    .quot_o  (qx),
    .flags_o (fx)
  );

  pcm_divider u_div_y (
    .clk_i   (clk_i),
    .num_i   ({ny_q, 8'b0}),
    .den_i   (w_q),
    .quot_o  (qy),
    .flags_o (fy)
  );

  // ---- final stage: sign, saturation, zero denominator
  function automatic logic signed [15:0] fix_q(
    input logic [pcm_pkg::QuoW-1:0] q,
    input pcm_pkg::quot_flags_t     f
  );
    logic signed [15:0] m;
    m = $signed({1'b0, q});
    if (f.wzero) begin
      fix_q = f.nzero ? 16'sd0 : (f.nneg ? pcm_pkg::SatNeg : pcm_pkg::SatPos);
    end else if (f.sat) begin
      fix_q = f.neg ? pcm_pkg::SatNeg : pcm_pkg::SatPos;
    end else begin
      fix_q = f.neg ? -m : m;
    end
  endfunction

  pcm_pkg::result_t res_q;

  always_ff @(posedge clk_i) begin
    res_q.mapped_x <= fix_q(qx, fx);
    res_q.mapped_y <= fix_q(qy, fy);
    res_q.is_white <= wht_q[Lat-1];
    res_q.overflow <= fx.wzero || fx.sat || fy.sat;
  end

  assign result_o       = res_q;
  assign result_valid_o = vld_q[Lat];

  // ---- assertions
  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.mapped_x != -16'sd32768 &&
                        result_o.mapped_y != -16'sd32768))
    else $error("mapped coordinate reached -32768");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(Lat+1) result_valid_o)
    else $error("result strobe missing after accept");

  // zero denominator over two zero numerators flags overflow at (0, 0)
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.mapped_x != pcm_pkg::SatPos &&
     result_o.mapped_x != pcm_pkg::SatNeg && result_o.mapped_y != pcm_pkg::SatPos &&
     result_o.mapped_y != pcm_pkg::SatNeg &&
     (result_o.mapped_x != 16'sd0 || result_o.mapped_y != 16'sd0)) |->
      !result_o.overflow)
    else $error("overflow set without saturated coordinate");

endmodule

[hdl/pcm_divider.sv]
// Pipelined restoring divider: |num| / |den|, one quotient bit per stage.
module pcm_divider (
  input  logic                                  clk_i,
  input  logic signed [pcm_pkg::NumW-1:0]       num_i,
  input  logic signed [pcm_pkg::SumW-1:0]       den_i,
  output logic [pcm_pkg::QuoW-1:0]              quot_o,
  output pcm_pkg::quot_flags_t                  flags_o
);

  localparam int NW = pcm_pkg::NumW;
  localparam int DW = pcm_pkg::SumW;
  localparam int QW = pcm_pkg::QuoW;
  localparam int CW = DW + QW;  // width of shifted divisor

  // stage A: magnitudes and signs
  logic [NW-1:0]        nmag_q;
  logic [DW-1:0]        dmag_q;
  pcm_pkg::quot_flags_t fa_q;

  always_ff @(posedge clk_i) begin
    nmag_q      <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    dmag_q      <= den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
    fa_q.neg    <= num_i[NW-1] ^ den_i[DW-1];
    fa_q.sat    <= 1'b0;
    fa_q.wzero  <= (den_i == '0);
    fa_q.nneg   <= num_i[NW-1];
    fa_q.nzero  <= (num_i == '0);
  end

  // stage B: range check against den * 2^15
  logic [NW-1:0]        rem_q [QW+1];
  logic [DW-1:0]        den_q [QW+1];
  logic [QW-1:0]        quo_q [QW+1];
  pcm_pkg::quot_flags_t flg_q [QW+1];
  logic [CW-1:0]        dtop;

  assign dtop = {dmag_q, QW'(0)};

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= nmag_q;
    den_q[0]  <= dmag_q;
    quo_q[0]  <= '0;
    flg_q[0]  <= '{neg:   fa_q.neg,
                   sat:   !fa_q.wzero && (CW'(nmag_q) >= dtop),
                   wzero: fa_q.wzero,
                   nneg:  fa_q.nneg,
                   nzero: fa_q.nzero};
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int Sh = QW - 1 - k;
    logic [CW-1:0] dsh;
    logic [CW-1:0] rext;
    logic          take;

    assign dsh  = CW'(den_q[k]) << Sh;
    assign rext = CW'(rem_q[k]);
    assign take = (rext >= dsh);

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= take ? NW'(rext - dsh) : rem_q[k];
      den_q[k+1] <= den_q[k];
      quo_q[k+1] <= {quo_q[k][QW-2:0], take};
      flg_q[k+1] <= flg_q[k];
    end
  end

  assign quot_o  = quo_q[QW];
  assign flags_o = flg_q[QW];

endmodule
